// ----- hw/rtl/diff_drive_pose_predict_top_defines.svh -----
// Assertion macros for the pose predictor checker.
// Used by ddpp_checker.sv only; no other dependencies.
`ifndef DIFF_DRIVE_POSE_PREDICT_TOP_DEFINES_SVH
`define DIFF_DRIVE_POSE_PREDICT_TOP_DEFINES_SVH

// Check that cons holds dly cycles after ante.
`define DDPP_ASSERT_DLY(lbl, clk, rstn, dly, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##dly (cons)) \
		else $error("pose predictor assertion failed");

// Check that cons holds in the same cycle as ante.
`define DDPP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("pose predictor assertion failed");

`endif

// ----- hw/rtl/ddpp_pkg.sv -----
// Shared types and constants of the pose predictor.
// No dependencies; imported by every module of the block.
package ddpp_pkg;

	localparam int NUM_CELLS = 32;
	localparam int ZW        = 34;
	localparam int NUM_W     = 32;
	localparam int DEN_W     = 16;
	localparam int FRONT_LAT = 5;
	localparam int BACK_LAT  = 4;
	localparam int LATENCY   = FRONT_LAT + NUM_CELLS + BACK_LAT;

	localparam logic [15:0] DT_RESET = 16'd3072;
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
	localparam int unsigned INV_TWO_PI_Q32 = 683565276;
	localparam logic [15:0] INV_HI = 16'(INV_TWO_PI_Q32 >> 15);
	localparam logic [15:0] INV_LO = 16'(INV_TWO_PI_Q32 % 32768);

	localparam logic [31:0] ATAN_TURNS [NUM_CELLS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
	};

	// Data handed from cell to cell: two rotation lanes and one divider step
	typedef struct packed {
		logic signed [ZW-1:0] x0;
		logic signed [ZW-1:0] y0;
		logic signed [ZW-1:0] z0;
		logic signed [ZW-1:0] x1;
		logic signed [ZW-1:0] y1;
		logic signed [ZW-1:0] z1;
		logic                 neg0;
		logic                 neg1;
		logic [NUM_W-1:0]     num;
		logic [DEN_W-1:0]     rem;
		logic [NUM_W-1:0]     quo;
		logic [DEN_W-1:0]     den;
	} cell_t;

	// Per-item control flags
	typedef struct packed {
		logic straight;
		logic rneg;
	} ctl_t;

	typedef struct packed {
		logic signed [ZW-1:0] z;
		logic                 neg;
	} fold_t;

	// Fold a 32-bit turn angle into the quarter-turn range
	function automatic fold_t fold_angle(input logic [31:0] t);
		fold_t f;
		f.z = $signed({{(ZW-32){t[31]}}, t});
		f.neg = 1'b0;
		if (f.z > $signed(ZW'(34'sd1073741824))) begin
			f.z = f.z - $signed(ZW'(34'sd2147483648));
			f.neg = 1'b1;
		end else if (f.z < -$signed(ZW'(34'sd1073741824))) begin
			f.z = f.z + $signed(ZW'(34'sd2147483648));
			f.neg = 1'b1;
		end
		return f;
	endfunction

endpackage

// ----- hw/rtl/ddpp_cell.sv -----
// One cell of the chain: one rotation step on both angle lanes (when DO_ROT is set)
// and one restoring divide step. Depends on ddpp_pkg.
module ddpp_cell #(
	parameter int IDX    = 0,
	parameter bit DO_ROT = 1'b1
) (
	input  logic            clk,
	input  ddpp_pkg::cell_t d,
	output ddpp_pkg::cell_t q
);
	import ddpp_pkg::*;

	localparam logic signed [ZW-1:0] ATAN_S = $signed(ZW'(ATAN_TURNS[IDX]));

	cell_t        nxt;
	logic [DEN_W:0] trial;

	// Rotate both lanes and shift one quotient bit in
	always_comb begin
		nxt = d;
		if (DO_ROT) begin
			if (!d.z0[ZW-1]) begin
				nxt.x0 = d.x0 - (d.y0 >>> IDX);
				nxt.y0 = d.y0 + (d.x0 >>> IDX);
				nxt.z0 = d.z0 - ATAN_S;
			end else begin
				nxt.x0 = d.x0 + (d.y0 >>> IDX);
				nxt.y0 = d.y0 - (d.x0 >>> IDX);
				nxt.z0 = d.z0 + ATAN_S;
			end
			if (!d.z1[ZW-1]) begin
				nxt.x1 = d.x1 - (d.y1 >>> IDX);
				nxt.y1 = d.y1 + (d.x1 >>> IDX);
				nxt.z1 = d.z1 - ATAN_S;
			end else begin
				nxt.x1 = d.x1 + (d.y1 >>> IDX);
				nxt.y1 = d.y1 - (d.x1 >>> IDX);
				nxt.z1 = d.z1 + ATAN_S;
			end
		end
		trial   = {d.rem, d.num[NUM_W-1]};
		nxt.num = {d.num[NUM_W-2:0], 1'b0};
		if (trial >= {1'b0, d.den}) begin
			nxt.rem = DEN_W'(trial - {1'b0, d.den});
			nxt.quo = {d.quo[NUM_W-2:0], 1'b1};
		end else begin
			nxt.rem = trial[DEN_W-1:0];
			nxt.quo = {d.quo[NUM_W-2:0], 1'b0};
		end
	end

	// Hand the word to the next cell
	always_ff @(posedge clk) begin
		q <= nxt;
	end

endmodule

// ----- hw/rtl/ddpp_back.sv -----
// Output stages: sine/cosine sign fix, radius clamp, displacement multiply,
// rounding, position add and clamp. Depends on ddpp_pkg.
module ddpp_back #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  ddpp_pkg::cell_t        res,
	input  ddpp_pkg::ctl_t         ctl,
	input  logic signed [31:0]     pos_x,
	input  logic signed [31:0]     pos_y,
	input  logic [ANGLE_BITS-1:0]  nh,
	input  logic signed [31:0]     vdt,
	output logic                   done,
	output logic signed [31:0]     new_x,
	output logic signed [31:0]     new_y,
	output logic [ANGLE_BITS-1:0]  new_heading,
	output logic                   saturated
);
	import ddpp_pkg::*;

	localparam logic signed [40:0] POS_MAX = 41'sd2147483647;
	localparam logic signed [40:0] POS_MIN = -41'sd2147483648;

	logic signed [ZW-1:0] c0, s0, c1, s1;
	logic signed [32:0]   rfull;
	logic signed [31:0]   rad;
	logic                 rsat;

	logic                  vld_s1, vld_s2, vld_s3;
	logic signed [32:0]    ax_s1;
	logic signed [ZW:0]    bx_s1, by_s1;
	logic                  sat_s1, sat_s2, sat_s3;
	logic                  str_s1, str_s2;
	logic signed [31:0]    px_s1, py_s1, px_s2, py_s2, px_s3, py_s3;
	logic [ANGLE_BITS-1:0] nh_s1, nh_s2, nh_s3;
	logic [67:0]           mx_s2, my_s2;
	logic [67:0]           half, sumx, sumy;
	logic signed [39:0]    rx_s3, ry_s3;
	logic signed [40:0]    tx, ty;

	// Undo the fold and form the radius
	always_comb begin
		c0 = res.neg0 ? -res.x0 : res.x0;
		s0 = res.neg0 ? -res.y0 : res.y0;
		c1 = res.neg1 ? -res.x1 : res.x1;
		s1 = res.neg1 ? -res.y1 : res.y1;
		rfull = ctl.rneg ? -$signed({1'b0, res.quo}) : $signed({1'b0, res.quo});
		rsat  = !ctl.rneg && res.quo[31];
		rad   = rsat ? 32'sh7fffffff : rfull[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done   <= vld_s3;
		end
	end

	// Select multiplier operands for a straight or an arc move
	always_ff @(posedge clk) begin
		if (ctl.straight) begin
			ax_s1 <= {vdt[31], vdt};
			bx_s1 <= {c0[ZW-1], c0};
			by_s1 <= {s0[ZW-1], s0};
		end else begin
			ax_s1 <= {rad[31], rad};
			bx_s1 <= {s1[ZW-1], s1} - {s0[ZW-1], s0};
			by_s1 <= {c0[ZW-1], c0} - {c1[ZW-1], c1};
		end
		sat_s1 <= !ctl.straight && rsat;
		str_s1 <= ctl.straight;
		px_s1  <= pos_x;
		py_s1  <= pos_y;
		nh_s1  <= nh;
	end

	// Multiply: sign-extended operands, low product bits kept
	always_ff @(posedge clk) begin
		mx_s2  <= {{35{ax_s1[32]}}, ax_s1} * {{33{bx_s1[ZW]}}, bx_s1};
		my_s2  <= {{35{ax_s1[32]}}, ax_s1} * {{33{by_s1[ZW]}}, by_s1};
		sat_s2 <= sat_s1;
		str_s2 <= str_s1;
		px_s2  <= px_s1;
		py_s2  <= py_s1;
		nh_s2  <= nh_s1;
	end

	// Round half away from zero
	always_comb begin
		half = str_s2 ? (68'd1 << 37) : (68'd1 << 29);
		sumx = mx_s2 + half - {67'd0, mx_s2[67]};
		sumy = my_s2 + half - {67'd0, my_s2[67]};
	end

	always_ff @(posedge clk) begin
		if (str_s2) begin
			rx_s3 <= 40'($signed(sumx) >>> 38);
			ry_s3 <= 40'($signed(sumy) >>> 38);
		end else begin
			rx_s3 <= 40'($signed(sumx) >>> 30);
			ry_s3 <= 40'($signed(sumy) >>> 30);
		end
		sat_s3 <= sat_s2;
		px_s3  <= px_s2;
		py_s3  <= py_s2;
		nh_s3  <= nh_s2;
	end

	// Add to position and clamp
	always_comb begin
		tx = {{9{px_s3[31]}}, px_s3} + {rx_s3[39], rx_s3};
		ty = {{9{py_s3[31]}}, py_s3} + {ry_s3[39], ry_s3};
	end

	always_ff @(posedge clk) begin
		priority if (tx > POS_MAX) new_x <= POS_MAX[31:0];
		else if (tx < POS_MIN) new_x <= POS_MIN[31:0];
		else new_x <= tx[31:0];
		priority if (ty > POS_MAX) new_y <= POS_MAX[31:0];
		else if (ty < POS_MIN) new_y <= POS_MIN[31:0];
		else new_y <= ty[31:0];
		saturated   <= sat_s3 || tx > POS_MAX || tx < POS_MIN || ty > POS_MAX || ty < POS_MIN;
		new_heading <= nh_s3;
	end

endmodule

// ----- hw/rtl/diff_drive_pose_predict_top.sv -----
// A word taken with start passes 5 front stages, the 32-cell chain that runs
// the radius divide and both angle rotations, and 4 output stages, and then
// appears on done. Throughput: one word per cycle; busy stays low, the
// receiver cannot stall.
// Reset clears all valid flags and sets delta_t to 3072 (0.75 s).
module diff_drive_pose_predict_top #(
	parameter int CORDIC_ITERATIONS = 16,
	parameter int ANGLE_BITS        = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [15:0]            cfg_data,
	input  logic                   start,
	output logic                   busy,
	input  logic signed [31:0]     pos_x,
	input  logic signed [31:0]     pos_y,
	input  logic [ANGLE_BITS-1:0]  heading,
	input  logic signed [15:0]     lin_vel,
	input  logic signed [15:0]     ang_vel,
	output logic                   done,
	output logic signed [31:0]     new_x,
	output logic signed [31:0]     new_y,
	output logic [ANGLE_BITS-1:0]  new_heading,
	output logic                   saturated
);
	import ddpp_pkg::*;

	localparam int RSH = 56 - ANGLE_BITS;
	localparam logic [63:0] RHALF = 64'd1 << (RSH - 1);

	typedef struct packed {
		logic signed [31:0]    pos_x;
		logic signed [31:0]    pos_y;
		logic [ANGLE_BITS-1:0] head;
		logic signed [31:0]    vdt;
		ctl_t                  ctl;
		logic [NUM_W-1:0]      num;
		logic [DEN_W-1:0]      den;
	} pl_t;

	typedef struct packed {
		logic signed [31:0]    pos_x;
		logic signed [31:0]    pos_y;
		logic [ANGLE_BITS-1:0] nh;
		logic signed [31:0]    vdt;
		ctl_t                  ctl;
	} sd_t;

	logic [15:0] dt_q;
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [NUM_CELLS-1:0] vld_q;

	logic signed [31:0]    px_s1, py_s1;
	logic [ANGLE_BITS-1:0] head_s1;
	logic signed [15:0]    lin_s1, ang_s1;
	logic [15:0]           dt_s1, lmag, amag;

	pl_t         pl_s2, pl_s3, pl_s4, pl_s5;
	logic [32:0] wdt_s2;
	logic [47:0] phi_s3, plo_s3;
	logic [63:0] p_s4, rsum;
	logic [ANGLE_BITS-1:0] nh_s5;

	fold_t f0, f1;
	cell_t cell_d [NUM_CELLS+1];
	sd_t   side_q [NUM_CELLS];

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// Hold the step length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= DT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dt_q <= cfg_data;
		end
	end

	// Advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_q  <= '0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_q  <= {vld_q[NUM_CELLS-2:0], vld_s5};
		end
	end

	// Capture the input word
	always_ff @(posedge clk) begin
		px_s1   <= pos_x;
		py_s1   <= pos_y;
		head_s1 <= heading;
		lin_s1  <= lin_vel;
		ang_s1  <= ang_vel;
		dt_s1   <= dt_q;
	end

	assign lmag = lin_s1[15] ? 16'(-lin_s1) : lin_s1;
	assign amag = ang_s1[15] ? 16'(-ang_s1) : ang_s1;

	// Speed times step; set up the divide operands
	always_ff @(posedge clk) begin
		wdt_s2           <= {{17{ang_s1[15]}}, ang_s1} * {17'd0, dt_s1};
		pl_s2.vdt        <= $signed({{16{lin_s1[15]}}, lin_s1} * {16'd0, dt_s1});
		pl_s2.pos_x      <= px_s1;
		pl_s2.pos_y      <= py_s1;
		pl_s2.head       <= head_s1;
		pl_s2.ctl.straight <= (ang_s1 == 16'sd0);
		pl_s2.ctl.rneg   <= lin_s1[15] ^ ang_s1[15];
		pl_s2.num        <= {lmag, 16'd0};
		pl_s2.den        <= amag;
	end

	// Turn angle to binary angle: two partial products
	always_ff @(posedge clk) begin
		phi_s3 <= {{15{wdt_s2[32]}}, wdt_s2} * {32'd0, INV_HI};
		plo_s3 <= {{15{wdt_s2[32]}}, wdt_s2} * {32'd0, INV_LO};
		pl_s3  <= pl_s2;
	end

	always_ff @(posedge clk) begin
		p_s4  <= ({{16{phi_s3[47]}}, phi_s3} << 15) + {{16{plo_s3[47]}}, plo_s3};
		pl_s4 <= pl_s3;
	end

	// Round the heading step and wrap the new heading
	assign rsum = p_s4 + RHALF - {63'd0, p_s4[63]};

	always_ff @(posedge clk) begin
		nh_s5 <= pl_s4.head + rsum[RSH+ANGLE_BITS-1:RSH];
		pl_s5 <= pl_s4;
	end

	// Load the first cell
	always_comb begin
		f0 = fold_angle({pl_s5.head, {(32-ANGLE_BITS){1'b0}}});
		f1 = fold_angle({nh_s5, {(32-ANGLE_BITS){1'b0}}});
		cell_d[0].x0   = $signed({{(ZW-32){1'b0}}, CORDIC_GAIN_Q30});
		cell_d[0].y0   = '0;
		cell_d[0].z0   = f0.z;
		cell_d[0].neg0 = f0.neg;
		cell_d[0].x1   = $signed({{(ZW-32){1'b0}}, CORDIC_GAIN_Q30});
		cell_d[0].y1   = '0;
		cell_d[0].z1   = f1.z;
		cell_d[0].neg1 = f1.neg;
		cell_d[0].num  = pl_s5.num;
		cell_d[0].rem  = '0;
		cell_d[0].quo  = '0;
		cell_d[0].den  = pl_s5.den;
	end

	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_chain
		ddpp_cell #(
			.IDX    (g),
			.DO_ROT (g < CORDIC_ITERATIONS)
		) u_cell (
			.clk (clk),
			.d   (cell_d[g]),
			.q   (cell_d[g+1])
		);
	end

	// Carry the side word alongside the chain
	always_ff @(posedge clk) begin
		side_q[0].pos_x <= pl_s5.pos_x;
		side_q[0].pos_y <= pl_s5.pos_y;
		side_q[0].nh    <= nh_s5;
		side_q[0].vdt   <= pl_s5.vdt;
		side_q[0].ctl   <= pl_s5.ctl;
		for (int i = 1; i < NUM_CELLS; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	ddpp_back #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (vld_q[NUM_CELLS-1]),
		.res         (cell_d[NUM_CELLS]),
		.ctl         (side_q[NUM_CELLS-1].ctl),
		.pos_x       (side_q[NUM_CELLS-1].pos_x),
		.pos_y       (side_q[NUM_CELLS-1].pos_y),
		.nh          (side_q[NUM_CELLS-1].nh),
		.vdt         (side_q[NUM_CELLS-1].vdt),
		.done        (done),
		.new_x       (new_x),
		.new_y       (new_y),
		.new_heading (new_heading),
		.saturated   (saturated)
	);

endmodule

// ----- hw/rtl/ddpp_checker.sv -----
// Port-level checks of the pose predictor, bound to the top level.
// Depends on ddpp_pkg and diff_drive_pose_predict_top_defines.svh.
`include "diff_drive_pose_predict_top_defines.svh"

module ddpp_checker #(
	parameter int ANGLE_BITS = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic [ANGLE_BITS-1:0] heading,
	input logic signed [15:0]    ang_vel,
	input logic [ANGLE_BITS-1:0] new_heading
);
	import ddpp_pkg::*;

	// Every accepted word yields one result a fixed time later
	`DDPP_ASSERT_DLY(a_done_after_start, clk, arst_n, LATENCY, start && !busy, done)
	// No result without a word accepted a fixed time before
	`DDPP_ASSERT_NOW(a_no_spurious_done, clk, arst_n, done, $past(start && !busy, LATENCY))
	// A straight move keeps its heading
	`DDPP_ASSERT_DLY(a_straight_heading, clk, arst_n, LATENCY, start && !busy && ang_vel == 16'sd0, new_heading == $past(heading, LATENCY))

endmodule

bind diff_drive_pose_predict_top ddpp_checker #(.ANGLE_BITS(ANGLE_BITS)) u_ddpp_checker (.*);

// ----- bench/tb_diff_drive_pose_predict_top.sv -----
// Self-checking bench for the pose predictor: queued driver, done-strobe monitor.
// Depends on diff_drive_pose_predict_top and ddpp_pkg (latency and reset step).
module tb_diff_drive_pose_predict_top;
	import ddpp_pkg::*;

	typedef struct {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [15:0]        hd;
		logic signed [15:0] lv;
		logic signed [15:0] av;
	} move_t;

	typedef struct {
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic [15:0]        nh;
		logic               sat;
	} pose_t;

	localparam int ITERS = 16;
	localparam longint GAIN = 652032874;
	localparam longint INV2PI = 683565276;
	localparam longint ATAN_TAB [16] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861
	};
	localparam int TIMEOUT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] pos_x = '0, pos_y = '0;
	logic [15:0] heading = '0;
	logic signed [15:0] lin_vel = '0, ang_vel = '0;
	logic done;
	logic signed [31:0] new_x, new_y;
	logic [15:0] new_heading;
	logic saturated;

	move_t pending_moves[$];
	pose_t expected_poses[$];
	logic [15:0] step_len = DT_RESET;
	logic hold_moves = 1'b0;
	logic no_gaps = 1'b0;
	int errors = 0;
	int mismatches = 0;
	int cycles = 0;

	diff_drive_pose_predict_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.pos_x(pos_x), .pos_y(pos_y), .heading(heading),
		.lin_vel(lin_vel), .ang_vel(ang_vel),
		.done(done), .new_x(new_x), .new_y(new_y),
		.new_heading(new_heading), .saturated(saturated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint round_away(longint v, int n);
		longint unsigned mag, r;
		mag = (v < 0) ? longint'(0) - v : v;
		r = (mag + (64'd1 << (n - 1))) >> n;
		return (v < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint clamp_s32(longint v, ref logic flag);
		if (v > 64'sd2147483647) begin
			flag = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			flag = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Rotate the gain vector to a binary angle; fold to the right half first
	task automatic rotate_angle(input logic [15:0] ang, output longint c, output longint s);
		logic [31:0] t;
		longint z, x, y, xs, ys;
		logic flip;
		t = {ang, 16'h0};
		z = longint'($signed(t));
		flip = 1'b0;
		x = GAIN;
		y = 0;
		if (z > 64'sd1073741824) begin
			z = z - 64'sd2147483648;
			flip = 1'b1;
		end else if (z < -64'sd1073741824) begin
			z = z + 64'sd2147483648;
			flip = 1'b1;
		end
		for (int i = 0; i < ITERS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
			end else begin
				x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// Predict the pose after one step of dt
	task automatic predict_pose(input move_t m, input logic [15:0] dt, output pose_t p);
		longint c0, s0, c1, s1, vdt, wdt, dth, rad, nx, ny;
		logic sat;
		logic [15:0] nh;
		sat = 1'b0;
		rotate_angle(m.hd, c0, s0);
		if (m.av == 0) begin
			vdt = longint'(m.lv) * longint'(dt);
			nh = m.hd;
			nx = longint'(m.px) + round_away(vdt * c0, 38);
			ny = longint'(m.py) + round_away(vdt * s0, 38);
		end else begin
			wdt = longint'(m.av) * longint'(dt);
			dth = round_away(wdt * INV2PI, 40);
			rad = clamp_s32((longint'(m.lv) * 65536) / longint'(m.av), sat);
			nh = 16'(longint'(m.hd) + dth);
			rotate_angle(nh, c1, s1);
			nx = longint'(m.px) + round_away(rad * (s1 - s0), 30);
			ny = longint'(m.py) - round_away(rad * (c1 - c0), 30);
		end
		p.nx = 32'(clamp_s32(nx, sat));
		p.ny = 32'(clamp_s32(ny, sat));
		p.nh = nh;
		p.sat = sat;
	endtask

	// Append a move to the driver queue
	task automatic add_move(input move_t m);
		pending_moves.insert(pending_moves.size(), m);
	endtask

	// Driver: record accepted word, then present the next one or idle
	always @(posedge clk or negedge arst_n) begin
		pose_t p;
		move_t m;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				m.px = pos_x; m.py = pos_y; m.hd = heading;
				m.lv = lin_vel; m.av = ang_vel;
				predict_pose(m, step_len, p);
				expected_poses.insert(expected_poses.size(), p);
			end
			if (cfg_valid && cfg_ready)
				step_len <= cfg_data;
			if (!start || !busy) begin
				if (pending_moves.size() > 0 && !hold_moves &&
				    (no_gaps || $urandom_range(99) >= 35)) begin
					m = pending_moves.pop_front();
					pos_x <= m.px; pos_y <= m.py; heading <= m.hd;
					lin_vel <= m.lv; ang_vel <= m.av;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each done word against the oldest prediction
	always @(posedge clk) begin
		pose_t e;
		cycles <= cycles + 1;
		if (arst_n && done) begin
			if (expected_poses.size() == 0) begin
				errors <= errors + 1;
				if (mismatches < 10)
					$display("unexpected result x=%0d y=%0d h=%0d", new_x, new_y, new_heading);
				mismatches <= mismatches + 1;
			end else begin
				e = expected_poses.pop_front();
				if (new_x !== e.nx || new_y !== e.ny || new_heading !== e.nh ||
				    saturated !== e.sat) begin
					errors <= errors + 1;
					if (mismatches < 10)
						$display("mismatch: exp x=%0d y=%0d h=%0d s=%0b got x=%0d y=%0d h=%0d s=%0b",
							e.nx, e.ny, e.nh, e.sat, new_x, new_y, new_heading, saturated);
					mismatches <= mismatches + 1;
				end
			end
		end
		if (cycles > TIMEOUT) begin
			$display("[diff_drive_pose_predict_top] ERROR");
			$finish;
		end
	end

	function automatic move_t rand_move();
		move_t m;
		int k;
		m.px = $urandom;
		m.py = $urandom;
		m.hd = 16'($urandom);
		m.lv = 16'($urandom);
		m.av = 16'($urandom);
		k = $urandom_range(99);
		if (k < 20) m.av = 0;
		else if (k < 30) m.av = $signed(16'($urandom_range(4))) - 16'sd2;
		else if (k < 40) m.av = 16'($urandom_range(511)) - 16'sd256;
		if ($urandom_range(9) == 0) m.lv = 0;
		if ($urandom_range(3) == 0) begin
			m.px = $signed(16'($urandom)) <<< 8;
			m.py = $signed(16'($urandom)) <<< 8;
		end
		return m;
	endfunction

	function automatic move_t mk(logic signed [31:0] px, logic signed [31:0] py,
		logic [15:0] hd, logic signed [15:0] lv, logic signed [15:0] av);
		move_t m;
		m.px = px; m.py = py; m.hd = hd; m.lv = lv; m.av = av;
		return m;
	endfunction

	task automatic wait_idle();
		while (pending_moves.size() > 0 || start || expected_poses.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_step(input logic [15:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [15:0] steps [6];
		steps = '{DT_RESET, 16'd65535, 16'd0, 16'd1, 16'd4096, 16'h0};
		steps[5] = 16'($urandom);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, straight and arc, saturation, zero speed
		add_move(mk(0, 0, 0, 0, 0));
		add_move(mk(0, 0, 16'hFFFF, 16'sh7FFF, 0));
		add_move(mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 16'sh7FFF, 0));
		add_move(mk(32'sh80000000, 32'sh80000000, 16'h8000, 16'sh7FFF, 0));
		add_move(mk(0, 0, 16'h4000, 16'sh8000, 0));
		add_move(mk(0, 0, 16'hC000, 16'sh7FFF, 16'sd1));
		add_move(mk(0, 0, 0, 16'sh8000, -16'sd1));
		add_move(mk(0, 0, 16'h2000, 16'sh7FFF, -16'sd1));
		add_move(mk(100, -100, 16'h1234, 0, 16'sd4096));
		add_move(mk(0, 0, 16'hFFFF, 0, 16'sh7FFF));
		add_move(mk(0, 0, 16'h0001, 0, 16'sh8000));
		add_move(mk(32'sh7FFFFFF0, 32'sh80000010, 16'h6000, 16'sh7FFF, 16'sd2));
		add_move(mk(32'sh80000010, 32'sh7FFFFFF0, 16'hA000, 16'sh8000, 16'sd3));
		add_move(mk(0, 0, 16'h4000, 16'sd4096, 16'sd4096));
		add_move(mk(0, 0, 16'hC001, 16'sh8000, 16'sh8000));
		add_move(mk(0, 0, 16'h3FFF, 16'sd1, 16'sh7FFF));
		add_move(mk(0, 0, 16'hBFFF, -16'sd1, 16'sh8000));
		add_move(mk(-1, -1, 16'hFFFF, 16'shFFFF, 16'shFFFF));
		add_move(mk(0, 0, 16'hFFF0, 16'sd0, 16'sd16));
		add_move(mk(32'h55555555, 32'hAAAAAAAA, 16'h5555, 16'sh5555, 16'shAAAA));

		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				wait_idle();
				write_step(steps[ph]);
			end
			for (int n = 0; n < 265; n++)
				add_move(rand_move());
			if (ph == 1) begin
				// long stretch back to back
				no_gaps <= 1'b1;
				while (pending_moves.size() > 0) @(posedge clk);
				no_gaps <= 1'b0;
			end
			if (ph == 3) begin
				// pause the sender until the pipeline drains
				while (pending_moves.size() > 130) @(posedge clk);
				hold_moves <= 1'b1;
				@(posedge clk);
				while (start || expected_poses.size() > 0) @(posedge clk);
				hold_moves <= 1'b0;
			end
		end
		wait_idle();

		if (errors == 0 && expected_poses.size() == 0)
			$display("[diff_drive_pose_predict_top] OK");
		else
			$display("[diff_drive_pose_predict_top] ERROR");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/ddpp_pkg.sv
hw/rtl/ddpp_cell.sv
hw/rtl/ddpp_back.sv
hw/rtl/diff_drive_pose_predict_top.sv
hw/rtl/ddpp_checker.sv
bench/tb_diff_drive_pose_predict_top.sv
